// ===== sv/assert_macros.svh =====
// Assertion macros for the intern table RTL, used by the table engine (hkit_back).
// Every macro assumes the house clock clk and active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HKIT_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HKIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hkit_pkg.sv =====
// Package for the hashed key intern table: field widths, codes and shared types.
// No dependencies; the interfaces, queue, front end, table engine and top import it.
`timescale 1ns / 1ps

package hkit_pkg;

  localparam int CHAR_W = 8;
  localparam int IDX_W  = 10;
  localparam int REF_W  = 16;
  localparam int HASH_W = 64;
  localparam int STAT_W = 3;

  // Widest slot index the table may need (TABLE_SLOTS up to 65536).
  localparam int POS_W = 16;

  localparam int TABLE_SLOTS_DEF = 2048;
  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int FIFO_DEPTH      = 2;

  localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
  localparam logic [REF_W-1:0]  REFS_MAX  = 16'hFFFF;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_ADDED    = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_BADINDEX = 3'd4
  } status_t;

  // Request handed from the front end to the table engine.
  typedef struct packed {
    logic              mode;
    logic [IDX_W-1:0]  rel;
    logic [HASH_W-1:0] hash;
    logic [POS_W-1:0]  pos;
  } cmd_t;

  // Status the table engine reports back to the front end.
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

// ===== sv/hkit_ifs.sv =====
// Valid/ready channel interfaces for the intern table: request and result.
// Depends on hkit_pkg for the field widths.
`timescale 1ns / 1ps

interface hkit_in_if import hkit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAR_W-1:0] key_char;
  logic              key_last;
  logic [IDX_W-1:0]  release_index;

  modport source (output valid, mode, key_char, key_last, release_index, input ready);
  modport sink   (input valid, mode, key_char, key_last, release_index, output ready);
endinterface

interface hkit_out_if import hkit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  entry_index;
  logic [REF_W-1:0]  ref_count;
  logic [HASH_W-1:0] key_hash;

  modport source (output valid, status, entry_index, ref_count, key_hash, input ready);
  modport sink   (input valid, status, entry_index, ref_count, key_hash, output ready);
endinterface

// ===== sv/hkit_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hkit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/hkit_fifo.sv =====
// Short request queue between the front end and the table engine.
// Depends on hkit_pkg for the default depth.
`timescale 1ns / 1ps

module hkit_fifo import hkit_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/hkit_front.sv =====
// Front end: takes request items, keeps the running djb2 hash and its slot residue,
// and queues finished keys and releases. Depends on hkit_pkg and hkit_ifs.
`timescale 1ns / 1ps

module hkit_front import hkit_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hkit_in_if.sink    in_ch,
  input  back_stat_t back_stat,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       fifo_full
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int RED_W  = SLOT_W + 6;
  localparam logic [RED_W-1:0]  SLOTS_X  = RED_W'(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] SEED_POS = SLOT_W'(HASH_SEED % TABLE_SLOTS);

  logic              a_vld_r, a_vld_nxt;
  logic              a_mode_r;
  logic              a_last_r;
  logic [IDX_W-1:0]  a_rel_r;
  logic [CHAR_W-1:0] a_ch_r;
  logic [SLOT_W-1:0] a_cm_r;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [SLOT_W-1:0] res_r, res_nxt;

  logic              accept, a_adv;
  logic [RED_W-1:0]  cm_x;
  logic [RED_W-1:0]  sum_x;
  logic [HASH_W-1:0] hash_new;
  logic [SLOT_W-1:0] res_new;

  // Character residue mod slot count, taken at accept (char < 16 * slots).
  always_comb begin
    cm_x = RED_W'(in_ch.key_char);
    for (int k = 3; k >= 0; k--) begin
      if (cm_x >= (SLOTS_X << k)) begin
        cm_x = cm_x - (SLOTS_X << k);
      end
    end
  end

  // Residue update: (33 * r + c) stays below 34 * slots, so six conditional subtracts.
  always_comb begin
    sum_x = (RED_W'(res_r) << 5) + RED_W'(res_r) + RED_W'(a_cm_r);
    for (int k = 5; k >= 0; k--) begin
      if (sum_x >= (SLOTS_X << k)) begin
        sum_x = sum_x - (SLOTS_X << k);
      end
    end
  end

  assign hash_new = (hash_r << 5) + hash_r + HASH_W'(a_ch_r);
  assign res_new  = SLOT_W'(sum_x);

  assign push   = a_vld_r && (a_mode_r || a_last_r);
  assign a_adv  = !push || !fifo_full;
  assign accept = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !back_stat.clearing && (!a_vld_r || a_adv);

  assign push_cmd.mode = a_mode_r;
  assign push_cmd.rel  = a_rel_r;
  assign push_cmd.hash = hash_new;
  assign push_cmd.pos  = POS_W'(res_new);

  always_comb begin
    a_vld_nxt = a_vld_r;
    hash_nxt  = hash_r;
    res_nxt   = res_r;
    if (accept) begin
      a_vld_nxt = 1'b1;
    end else if (a_adv) begin
      a_vld_nxt = 1'b0;
    end
    // Releases leave the key in progress alone.
    if (a_vld_r && a_adv && !a_mode_r) begin
      if (a_last_r) begin
        hash_nxt = HASH_SEED;
        res_nxt  = SEED_POS;
      end else begin
        hash_nxt = hash_new;
        res_nxt  = res_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      hash_r  <= HASH_SEED;
      res_r   <= SEED_POS;
    end else begin
      a_vld_r <= a_vld_nxt;
      hash_r  <= hash_nxt;
      res_r   <= res_nxt;
    end
    if (accept) begin
      a_mode_r <= in_ch.mode;
      a_last_r <= in_ch.key_last;
      a_rel_r  <= in_ch.release_index;
      a_ch_r   <= in_ch.key_char;
      a_cm_r   <= SLOT_W'(cm_x);
    end
  end

endmodule

// ===== sv/hkit_back.sv =====
// Table engine: clears the slot table after reset, probes it linearly for each key,
// and updates entry reference counts. Depends on hkit_pkg, hkit_ifs, hkit_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hkit_back import hkit_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic       fifo_empty,
  output logic       pop,
  output back_stat_t back_stat,
  hkit_out_if.source out_ch
);

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int ENT_W   = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int SLOT_DW = 1 + ENT_W + HASH_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_REFS
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              c_mode_r, c_mode_nxt;
  logic [IDX_W-1:0]  c_rel_r, c_rel_nxt;
  logic [HASH_W-1:0] c_hash_r, c_hash_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [SLOT_W:0]   probes_r, probes_nxt;
  logic [ENT_W-1:0]  ent_r, ent_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [IDX_W-1:0]  out_index_r, out_index_nxt;
  logic [REF_W-1:0]  out_refs_r, out_refs_nxt;
  logic [HASH_W-1:0] out_hash_r, out_hash_nxt;

  logic               slot_we, slot_re;
  logic [SLOT_W-1:0]  slot_waddr, slot_raddr;
  logic [SLOT_DW-1:0] slot_wdata, slot_rdata;
  logic               refs_we, refs_re;
  logic [ENT_W-1:0]   refs_waddr, refs_raddr;
  logic [REF_W-1:0]   refs_wdata, refs_rdata;

  logic               out_free;
  logic               rd_valid;
  logic [ENT_W-1:0]   rd_entry;
  logic [HASH_W-1:0]  rd_hash;
  logic [SLOT_W-1:0]  pos_inc;
  logic               table_done;
  logic               entries_full;
  logic [REF_W-1:0]   refs_up, refs_down;

  hkit_ram #(.WIDTH(SLOT_DW), .DEPTH(TABLE_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  hkit_ram #(.WIDTH(REF_W), .DEPTH(MAX_ENTRIES)) u_refs_ram (
    .clk   (clk),
    .we    (refs_we),
    .waddr (refs_waddr),
    .wdata (refs_wdata),
    .re    (refs_re),
    .raddr (refs_raddr),
    .rdata (refs_rdata)
  );

  assign out_free     = !out_valid_r || out_ch.ready;
  assign rd_valid     = slot_rdata[SLOT_DW-1];
  assign rd_entry     = slot_rdata[HASH_W +: ENT_W];
  assign rd_hash      = slot_rdata[HASH_W-1:0];
  assign pos_inc      = (pos_r == SLOT_LAST) ? '0 : pos_r + 1'b1;
  assign table_done   = ((probes_r + 1'b1) == (SLOT_W + 1)'(TABLE_SLOTS));
  assign entries_full = (cnt_r >= CNT_W'(MAX_ENTRIES));
  assign refs_up      = (refs_rdata == REFS_MAX) ? refs_rdata : refs_rdata + 1'b1;
  assign refs_down    = (refs_rdata == '0) ? refs_rdata : refs_rdata - 1'b1;

  assign back_stat.clearing = (state_r == S_CLEAR);

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    cnt_nxt        = cnt_r;
    c_mode_nxt     = c_mode_r;
    c_rel_nxt      = c_rel_r;
    c_hash_nxt     = c_hash_r;
    pos_nxt        = pos_r;
    probes_nxt     = probes_r;
    ent_nxt        = ent_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_refs_nxt   = out_refs_r;
    out_hash_nxt   = out_hash_r;
    pop            = 1'b0;
    slot_we        = 1'b0;
    slot_waddr     = pos_r;
    slot_wdata     = '0;
    slot_re        = 1'b0;
    slot_raddr     = pos_r;
    refs_we        = 1'b0;
    refs_waddr     = ent_r;
    refs_wdata     = '0;
    refs_re        = 1'b0;
    refs_raddr     = ent_r;

    unique case (state_r)
      S_CLEAR: begin
        slot_we     = 1'b1;
        slot_waddr  = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (!fifo_empty && out_free) begin
          pop        = 1'b1;
          c_mode_nxt = cmd.mode;
          c_rel_nxt  = cmd.rel;
          c_hash_nxt = cmd.hash;
          if (cmd.mode) begin
            if (CMP_W'(cmd.rel) >= CMP_W'(cnt_r)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_BADINDEX;
              out_index_nxt  = cmd.rel;
              out_refs_nxt   = '0;
              out_hash_nxt   = '0;
            end else begin
              refs_re    = 1'b1;
              refs_raddr = ENT_W'(cmd.rel);
              ent_nxt    = ENT_W'(cmd.rel);
              state_nxt  = S_REFS;
            end
          end else begin
            slot_re    = 1'b1;
            slot_raddr = SLOT_W'(cmd.pos);
            pos_nxt    = SLOT_W'(cmd.pos);
            probes_nxt = '0;
            state_nxt  = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        if (!rd_valid) begin
          // Empty slot ends the probe: add a new entry or report full.
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_hash_nxt  = c_hash_r;
            state_nxt     = S_IDLE;
            if (entries_full) begin
              out_status_nxt = ST_FULL;
              out_index_nxt  = '0;
              out_refs_nxt   = '0;
            end else begin
              slot_we        = 1'b1;
              slot_waddr     = pos_r;
              slot_wdata     = {1'b1, ENT_W'(cnt_r), c_hash_r};
              refs_we        = 1'b1;
              refs_waddr     = ENT_W'(cnt_r);
              refs_wdata     = REF_W'(1);
              cnt_nxt        = cnt_r + 1'b1;
              out_status_nxt = ST_ADDED;
              out_index_nxt  = IDX_W'(cnt_r);
              out_refs_nxt   = REF_W'(1);
            end
          end
        end else if (rd_hash == c_hash_r) begin
          refs_re    = 1'b1;
          refs_raddr = rd_entry;
          ent_nxt    = rd_entry;
          state_nxt  = S_REFS;
        end else if (table_done) begin
          // Every slot taken and none matched.
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FULL;
            out_index_nxt  = '0;
            out_refs_nxt   = '0;
            out_hash_nxt   = c_hash_r;
            state_nxt      = S_IDLE;
          end
        end else begin
          slot_re    = 1'b1;
          slot_raddr = pos_inc;
          pos_nxt    = pos_inc;
          probes_nxt = probes_r + 1'b1;
        end
      end

      S_REFS: begin
        if (out_free) begin
          refs_we       = 1'b1;
          refs_waddr    = ent_r;
          out_valid_nxt = 1'b1;
          out_index_nxt = IDX_W'(ent_r);
          state_nxt     = S_IDLE;
          if (c_mode_r) begin
            refs_wdata     = refs_down;
            out_status_nxt = ST_RELEASED;
            out_refs_nxt   = refs_down;
            out_hash_nxt   = '0;
          end else begin
            refs_wdata     = refs_up;
            out_status_nxt = ST_FOUND;
            out_refs_nxt   = refs_up;
            out_hash_nxt   = c_hash_r;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    c_mode_r     <= c_mode_nxt;
    c_rel_r      <= c_rel_nxt;
    c_hash_r     <= c_hash_nxt;
    pos_r        <= pos_nxt;
    probes_r     <= probes_nxt;
    ent_r        <= ent_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_refs_r   <= out_refs_nxt;
    out_hash_r   <= out_hash_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_index = out_index_r;
  assign out_ch.ref_count   = out_refs_r;
  assign out_ch.key_hash    = out_hash_r;

  `HKIT_ASSERT(a_cnt_limit, 1'b1, cnt_r <= CNT_W'(MAX_ENTRIES), "entry count past limit")
  `HKIT_ASSERT(a_no_pop_clear, state_r == S_CLEAR, !pop, "queue popped during clear")
  `HKIT_ASSERT(a_added_one, out_valid_r && out_status_r == ST_ADDED, out_refs_r == REF_W'(1), "new entry count not one")
  `HKIT_ASSERT_NEXT(a_cnt_hold, state_r == S_IDLE || state_r == S_REFS, cnt_r == $past(cnt_r), "entry count moved outside add")

endmodule

// ===== sv/hashed_key_intern_table_top.sv =====
// A non-final key character gives no result. A final character or a release passes the
// front-end register and the request queue; the table engine probes the slot table
// (keys) or reads the reference counts (hits, in-range releases) and registers the result.
// Input: one key character per cycle while the queue has room; the engine serves one
// request at a time, a 2-deep queue buffers them. Reset: synchronous, active low; then
// the slot table is cleared one slot a cycle, with in_ch.ready low throughout.
`timescale 1ns / 1ps

module hashed_key_intern_table_top import hkit_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hkit_in_if.sink    in_ch,
  hkit_out_if.source out_ch
);

  cmd_t       push_cmd;
  cmd_t       pop_cmd;
  logic       push, pop;
  logic       fifo_full, fifo_empty;
  back_stat_t back_stat;

  hkit_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .back_stat (back_stat),
    .push      (push),
    .push_cmd  (push_cmd),
    .fifo_full (fifo_full)
  );

  hkit_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .empty     (fifo_empty)
  );

  hkit_back #(.TABLE_SLOTS(TABLE_SLOTS), .MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (pop_cmd),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .back_stat  (back_stat),
    .out_ch     (out_ch)
  );

endmodule
